FILE: rtl/dnsa_pkg.sv
package dnsa_pkg;

   // Parse phases of the reply walker.
   localparam logic [3:0] PhHeader      = 4'd0;
   localparam logic [3:0] PhQName       = 4'd1;
   localparam logic [3:0] PhQLabel      = 4'd2;
   localparam logic [3:0] PhQPointer    = 4'd3;
   localparam logic [3:0] PhQFixed      = 4'd4;
   localparam logic [3:0] PhAName       = 4'd5;
   localparam logic [3:0] PhALabel      = 4'd6;
   localparam logic [3:0] PhAPointer    = 4'd7;
   localparam logic [3:0] PhAFixed      = 4'd8;
   localparam logic [3:0] PhASkip       = 4'd9;
   localparam logic [3:0] PhACapture    = 4'd10;
   localparam logic [3:0] PhDone        = 4'd11;
   localparam logic [3:0] PhBadId       = 4'd12;
   localparam logic [3:0] PhRcode       = 4'd13;

   // Result status codes.
   localparam logic [2:0] StatusFound    = 3'd0;
   localparam logic [2:0] StatusNoRecord = 3'd1;
   localparam logic [2:0] StatusRcode    = 3'd2;
   localparam logic [2:0] StatusBadId    = 3'd3;
   localparam logic [2:0] StatusShort    = 3'd4;

   // Message layout constants.
   localparam logic [3:0]  HeaderLastIndex    = 4'd11;
   localparam logic [3:0]  QuestionFixedLast  = 4'd3;
   localparam logic [3:0]  AnswerFixedLast    = 4'd9;
   localparam logic [1:0]  PointerTag         = 2'b11;
   localparam logic [3:0]  RcodeMask          = 4'hF;
   localparam logic [15:0] TypeA              = 16'd1;
   localparam logic [15:0] AddressLength      = 16'd4;

   // Result payload carried into the output register.
   typedef struct packed {
      logic        found;
      logic [31:0] address;
      logic [2:0]  status;
   } result_type;

endpackage

FILE: rtl/dns_reply_a_record_extractor.sv
// Parses a DNS reply presented one byte per item and, on the item marked last,
// delivers one result with the found flag, the IPv4 address of the first type-A
// answer with a four-byte rdlength, and a status code. A byte is accepted in
// every cycle unless input is held off: it lands in an input register, then
// the parser state and the result register are updated from that register.
// Input is held off only while a result is waiting in the output register
// and another last byte is ready to produce the next one. The expected
// transaction id is written through the csr port, which is always ready, and
// must be written between messages.
module dns_reply_a_record_extractor #(
   parameter int MAX_LABELS = 128
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [31:0] rsp_address,
   output logic [2:0]  rsp_status,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_expected_id
);
   import dnsa_pkg::*;

   localparam int LabelCountWidth = $clog2(MAX_LABELS + 1);

   // Configuration register.
   logic [15:0] expected_id_ff;

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // Parser state.
   logic [3:0]                 phase_ff, phase_in;
   logic [3:0]                 header_index_ff, header_index_in;
   logic [15:0]                reply_id_ff, reply_id_in;
   logic [3:0]                 response_code_ff, response_code_in;
   logic [15:0]                questions_left_ff, questions_left_in;
   logic [15:0]                answers_left_ff, answers_left_in;
   logic [7:0]                 label_bytes_left_ff, label_bytes_left_in;
   logic [LabelCountWidth-1:0] label_count_ff, label_count_in;
   logic [3:0]                 fixed_index_ff, fixed_index_in;
   logic [15:0]                record_type_ff, record_type_in;
   logic [15:0]                record_length_ff, record_length_in;
   logic [15:0]                data_bytes_left_ff, data_bytes_left_in;
   logic [31:0]                address_shift_ff, address_shift_in;
   logic                       found_flag_ff, found_flag_in;

   // Output register.
   logic       out_valid_ff, out_valid_in;
   result_type result_ff, result_in;

   logic advance;
   logic produce;

   // The held item moves on unless it would overwrite a result still waiting.
   assign advance   = !in_last_ff || !out_valid_ff || !rsp_stall;
   assign produce   = in_valid_ff && in_last_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign in_valid_in = req_valid || (in_valid_ff && !advance);

   assign csr_ready = 1'b1;

   // Next parser state for the byte in the input register.
   always_comb begin
      logic [7:0] b;
      logic       answer;
      logic       name_step;
      logic       start_questions;
      logic       start_answers;
      b = in_byte_ff;
      answer = 1'b0;
      name_step = 1'b0;
      start_questions = 1'b0;
      start_answers = 1'b0;

      phase_in            = phase_ff;
      header_index_in     = header_index_ff;
      reply_id_in         = reply_id_ff;
      response_code_in    = response_code_ff;
      questions_left_in   = questions_left_ff;
      answers_left_in     = answers_left_ff;
      label_bytes_left_in = label_bytes_left_ff;
      label_count_in      = label_count_ff;
      fixed_index_in      = fixed_index_ff;
      record_type_in      = record_type_ff;
      record_length_in    = record_length_ff;
      data_bytes_left_in  = data_bytes_left_ff;
      address_shift_in    = address_shift_ff;
      found_flag_in       = found_flag_ff;

      unique case (phase_ff)
         PhHeader: begin
            case (header_index_ff)
               4'd0: reply_id_in = {b, 8'h00};
               4'd1: reply_id_in = {reply_id_ff[15:8], b};
               4'd3: response_code_in = b[3:0] & RcodeMask;
               4'd4: questions_left_in = {b, 8'h00};
               4'd5: questions_left_in = {questions_left_ff[15:8], b};
               4'd6: answers_left_in = {b, 8'h00};
               4'd7: answers_left_in = {answers_left_ff[15:8], b};
               default: ;
            endcase
            if (header_index_ff >= HeaderLastIndex) begin
               if (reply_id_in != expected_id_ff) begin
                  phase_in = PhBadId;
               end else if (response_code_in != 4'd0) begin
                  phase_in = PhRcode;
               end else begin
                  start_questions = 1'b1;
               end
            end else begin
               header_index_in = header_index_ff + 4'd1;
            end
         end
         PhQName: begin
            name_step = 1'b1;
         end
         PhAName: begin
            name_step = 1'b1;
            answer = 1'b1;
         end
         PhQLabel, PhALabel: begin
            label_bytes_left_in = label_bytes_left_ff - 8'd1;
            if (label_bytes_left_in == 8'd0) begin
               phase_in = (phase_ff == PhALabel) ? PhAName : PhQName;
            end
         end
         PhQPointer: begin
            fixed_index_in = 4'd0;
            phase_in = PhQFixed;
         end
         PhAPointer: begin
            fixed_index_in = 4'd0;
            phase_in = PhAFixed;
         end
         PhQFixed: begin
            if (fixed_index_ff >= QuestionFixedLast) begin
               questions_left_in = questions_left_ff - 16'd1;
               start_questions = 1'b1;
            end else begin
               fixed_index_in = fixed_index_ff + 4'd1;
            end
         end
         PhAFixed: begin
            case (fixed_index_ff)
               4'd0: record_type_in = {b, 8'h00};
               4'd1: record_type_in = {record_type_ff[15:8], b};
               4'd8: record_length_in = {b, 8'h00};
               4'd9: record_length_in = {record_length_ff[15:8], b};
               default: ;
            endcase
            if (fixed_index_ff >= AnswerFixedLast) begin
               if (record_type_in == TypeA && record_length_in == AddressLength) begin
                  data_bytes_left_in = AddressLength;
                  address_shift_in = 32'd0;
                  phase_in = PhACapture;
               end else if (record_length_in == 16'd0) begin
                  answers_left_in = answers_left_ff - 16'd1;
                  start_answers = 1'b1;
               end else begin
                  data_bytes_left_in = record_length_in;
                  phase_in = PhASkip;
               end
            end else begin
               fixed_index_in = fixed_index_ff + 4'd1;
            end
         end
         PhASkip: begin
            data_bytes_left_in = data_bytes_left_ff - 16'd1;
            if (data_bytes_left_in == 16'd0) begin
               answers_left_in = answers_left_ff - 16'd1;
               start_answers = 1'b1;
            end
         end
         PhACapture: begin
            address_shift_in = {address_shift_ff[23:0], b};
            data_bytes_left_in = data_bytes_left_ff - 16'd1;
            if (data_bytes_left_in == 16'd0) begin
               found_flag_in = 1'b1;
               phase_in = PhDone;
            end
         end
         default: ;
      endcase

      // Name byte: pointer, terminator or label length.
      if (name_step) begin
         if (b[7:6] == PointerTag) begin
            phase_in = answer ? PhAPointer : PhQPointer;
         end else if (b == 8'd0) begin
            fixed_index_in = 4'd0;
            phase_in = answer ? PhAFixed : PhQFixed;
         end else if (label_count_ff >= LabelCountWidth'(MAX_LABELS)) begin
            phase_in = PhDone;
         end else begin
            label_count_in = label_count_ff + LabelCountWidth'(1);
            label_bytes_left_in = b;
            phase_in = answer ? PhALabel : PhQLabel;
         end
      end

      // Move to the next question or on to the answer section.
      if (start_questions) begin
         if (questions_left_in == 16'd0) begin
            start_answers = 1'b1;
         end else begin
            phase_in = PhQName;
            label_count_in = '0;
         end
      end
      if (start_answers) begin
         if (answers_left_in == 16'd0) begin
            phase_in = PhDone;
         end else begin
            phase_in = PhAName;
            label_count_in = '0;
         end
      end

      // Result for a last byte, judged on the updated state.
      result_in.found = found_flag_in;
      result_in.address = found_flag_in ? address_shift_in : 32'd0;
      if (phase_in == PhHeader) begin
         result_in.status = StatusShort;
      end else if (phase_in == PhBadId) begin
         result_in.status = StatusBadId;
      end else if (phase_in == PhRcode) begin
         result_in.status = StatusRcode;
      end else if (found_flag_in) begin
         result_in.status = StatusFound;
      end else begin
         result_in.status = StatusNoRecord;
      end

      // The last byte returns the parser to the start of a message.
      if (in_last_ff) begin
         phase_in            = PhHeader;
         header_index_in     = 4'd0;
         reply_id_in         = 16'd0;
         response_code_in    = 4'd0;
         questions_left_in   = 16'd0;
         answers_left_in     = 16'd0;
         label_bytes_left_in = 8'd0;
         label_count_in      = '0;
         fixed_index_in      = 4'd0;
         record_type_in      = 16'd0;
         record_length_in    = 16'd0;
         data_bytes_left_in  = 16'd0;
         address_shift_in    = 32'd0;
         found_flag_in       = 1'b0;
      end
   end

   // Output register holds a result until it is taken.
   always_comb begin
      if (produce) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control and parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff      <= 16'd0;
         in_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
         phase_ff            <= PhHeader;
         header_index_ff     <= 4'd0;
         reply_id_ff         <= 16'd0;
         response_code_ff    <= 4'd0;
         questions_left_ff   <= 16'd0;
         answers_left_ff     <= 16'd0;
         label_bytes_left_ff <= 8'd0;
         label_count_ff      <= '0;
         fixed_index_ff      <= 4'd0;
         record_type_ff      <= 16'd0;
         record_length_ff    <= 16'd0;
         data_bytes_left_ff  <= 16'd0;
         address_shift_ff    <= 32'd0;
         found_flag_ff       <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            expected_id_ff <= csr_expected_id;
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (in_valid_ff && advance) begin
            phase_ff            <= phase_in;
            header_index_ff     <= header_index_in;
            reply_id_ff         <= reply_id_in;
            response_code_ff    <= response_code_in;
            questions_left_ff   <= questions_left_in;
            answers_left_ff     <= answers_left_in;
            label_bytes_left_ff <= label_bytes_left_in;
            label_count_ff      <= label_count_in;
            fixed_index_ff      <= fixed_index_in;
            record_type_ff      <= record_type_in;
            record_length_ff    <= record_length_in;
            data_bytes_left_ff  <= data_bytes_left_in;
            address_shift_ff    <= address_shift_in;
            found_flag_ff       <= found_flag_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (produce) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_found   = result_ff.found;
   assign rsp_address = result_ff.address;
   assign rsp_status  = result_ff.status;

   // A found result always carries the found status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == StatusFound)
      else $error("found result without found status");

   // Without a record the address reads as zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_address == 32'd0)
      else $error("address nonzero with nothing found");

   // A last byte sends the parser back to the header.
   assert property (@(posedge clock) disable iff (reset)
      produce |=> phase_ff == PhHeader && header_index_ff == 4'd0 && !found_flag_ff)
      else $error("parser not cleared after last byte");

   // The label counter never passes the limit.
   assert property (@(posedge clock) disable iff (reset)
      label_count_ff <= LabelCountWidth'(MAX_LABELS))
      else $error("label count beyond limit");

endmodule

FILE: tb/sv/dns_reply_a_record_extractor_tb.sv
`timescale 1ns / 1ps

module dns_reply_a_record_extractor_tb;
   import dnsa_pkg::*;

   localparam int LabelLimit     = 128;
   localparam int HoldCycles     = 300;
   localparam int DrainCycles    = 6;
   localparam int CycleLimit     = 200000;
   localparam int SegmentBytes   = 100;
   localparam int SegmentReplies = 2;
   localparam int NumRows        = 22;

   localparam logic [15:0] TypeCname = 16'd5;
   localparam logic [15:0] TypeAaaa  = 16'd28;

   // Shapes of the hand-written reply messages.
   typedef enum logic [4:0] {
      KindFound,
      KindOneByte,
      KindShortHeader,
      KindEmpty,
      KindBadId,
      KindRcode,
      KindWriteId,
      KindPointer,
      KindSkipFirst,
      KindLongLabel,
      KindMaxLabels,
      KindTooManyLabels,
      KindTruncated,
      KindTrailing,
      KindHugeCounts,
      KindHugeLength,
      KindNoA
   } reply_kind_type;

   typedef struct packed {
      reply_kind_type kind;
      logic [31:0]    arg;
      logic           typed;
      result_type     want;
   } reply_row_type;

   // Directed replies; rows marked typed carry the result that must come back.
   reply_row_type plan [NumRows] = '{
      '{KindFound,         32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0000, StatusFound}},
      '{KindFound,         32'hFFFF_FFFF, 1'b1, '{1'b1, 32'hFFFF_FFFF, StatusFound}},
      '{KindOneByte,       32'h0,         1'b1, '{1'b0, 32'h0, StatusShort}},
      '{KindShortHeader,   32'h0,         1'b1, '{1'b0, 32'h0, StatusShort}},
      '{KindEmpty,         32'h0,         1'b1, '{1'b0, 32'h0, StatusNoRecord}},
      '{KindBadId,         32'h0,         1'b1, '{1'b0, 32'h0, StatusBadId}},
      '{KindRcode,         32'h0,         1'b1, '{1'b0, 32'h0, StatusRcode}},
      '{KindWriteId,       32'h0000_FFFF, 1'b0, '0},
      '{KindFound,         32'h0A00_0001, 1'b1, '{1'b1, 32'h0A00_0001, StatusFound}},
      '{KindBadId,         32'h0,         1'b1, '{1'b0, 32'h0, StatusBadId}},
      '{KindPointer,       32'h0,         1'b0, '0},
      '{KindSkipFirst,     32'hC0A8_0001, 1'b0, '0},
      '{KindLongLabel,     32'h8000_0001, 1'b0, '0},
      '{KindMaxLabels,     32'h7F00_0001, 1'b0, '0},
      '{KindTooManyLabels, 32'h0,         1'b1, '{1'b0, 32'h0, StatusNoRecord}},
      '{KindWriteId,       32'h0000_5A3C, 1'b0, '0},
      '{KindTruncated,     32'h0102_0304, 1'b1, '{1'b0, 32'h0, StatusNoRecord}},
      '{KindTrailing,      32'h0102_0304, 1'b0, '0},
      '{KindHugeCounts,    32'h0,         1'b1, '{1'b0, 32'h0, StatusNoRecord}},
      '{KindHugeLength,    32'h0,         1'b1, '{1'b0, 32'h0, StatusNoRecord}},
      '{KindNoA,           32'h0,         1'b1, '{1'b0, 32'h0, StatusNoRecord}},
      '{KindFound,         32'h5555_AAAA, 1'b0, '0}
   };

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic [7:0]  req_data_byte   = 8'h00;
   logic        req_last_byte   = 1'b0;
   logic        rsp_stall       = 1'b0;
   logic        csr_valid       = 1'b0;
   logic [15:0] csr_expected_id = 16'h0000;
   wire         req_stall;
   wire         rsp_valid;
   wire         rsp_found;
   wire  [31:0] rsp_address;
   wire  [2:0]  rsp_status;
   wire         csr_ready;

   dns_reply_a_record_extractor #(
      .MAX_LABELS(LabelLimit)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_found      (rsp_found),
      .rsp_address    (rsp_address),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_expected_id(csr_expected_id)
   );

   // Parser state of the local copy, plus its copy of the id register.
   logic [15:0] expected_id_copy = 16'h0000;
   logic [3:0]  parse_ph;
   logic [3:0]  hdr_pos;
   logic [15:0] msg_id;
   logic [3:0]  msg_rcode;
   logic [15:0] qd_left;
   logic [15:0] an_left;
   logic [7:0]  lbl_left;
   logic [7:0]  lbl_count;
   logic [3:0]  fix_pos;
   logic [15:0] rr_type;
   logic [15:0] rr_len;
   logic [15:0] rd_left;
   logic [31:0] addr_acc;
   logic        addr_done;

   // Lookup results that the block still owes, oldest first.
   result_type  dns_results_due[$];
   // Bytes of the reply message being sent.
   logic [7:0]  reply_bytes[$];

   bit idle_on = 1'b1;
   int hold_requests = 0;
   int bytes_sent = 0;
   int replies_sent = 0;
   int results_seen = 0;
   int addresses_found = 0;
   int mismatches = 0;
   int block_stall_cycles = 0;
   int id_writes = 0;

   // Clock generation.
   initial begin
      forever #4 clock = ~clock;
   end

   function automatic void clear_parse();
      parse_ph  = PhHeader;
      hdr_pos   = '0;
      msg_id    = '0;
      msg_rcode = '0;
      qd_left   = '0;
      an_left   = '0;
      lbl_left  = '0;
      lbl_count = '0;
      fix_pos   = '0;
      rr_type   = '0;
      rr_len    = '0;
      rd_left   = '0;
      addr_acc  = '0;
      addr_done = 1'b0;
   endfunction

   function automatic void open_answers();
      if (an_left == 0) begin
         parse_ph = PhDone;
      end else begin
         parse_ph  = PhAName;
         lbl_count = '0;
      end
   endfunction

   function automatic void open_questions();
      if (qd_left == 0) begin
         open_answers();
      end else begin
         parse_ph  = PhQName;
         lbl_count = '0;
      end
   endfunction

   function automatic void close_answer();
      an_left = an_left - 16'd1;
      open_answers();
   endfunction

   function automatic void close_name(input logic in_answer);
      fix_pos  = '0;
      parse_ph = in_answer ? PhAFixed : PhQFixed;
   endfunction

   // A name byte is a pointer, the terminating zero or a label length.
   function automatic void take_name_byte(input logic [7:0] b, input logic in_answer);
      if (b[7:6] == PointerTag) begin
         parse_ph = in_answer ? PhAPointer : PhQPointer;
      end else if (b == 8'h00) begin
         close_name(in_answer);
      end else if (lbl_count >= LabelLimit) begin
         parse_ph = PhDone;
      end else begin
         lbl_count = lbl_count + 8'd1;
         lbl_left  = b;
         parse_ph  = in_answer ? PhALabel : PhQLabel;
      end
   endfunction

   function automatic void take_label_byte(input logic in_answer);
      lbl_left = lbl_left - 8'd1;
      if (lbl_left == 0) begin
         parse_ph = in_answer ? PhAName : PhQName;
      end
   endfunction

   // Advances the local parser by one reply byte and forms the result on the last one.
   function automatic void parse_reply_byte(input logic [7:0] b, input logic last,
                                            output logic has_result, output result_type outcome);
      has_result = 1'b0;
      outcome    = '0;
      case (parse_ph)
         PhHeader: begin
            case (hdr_pos)
               4'd0: msg_id = {b, 8'h00};
               4'd1: msg_id[7:0] = b;
               4'd3: msg_rcode = b[3:0] & RcodeMask;
               4'd4: qd_left = {b, 8'h00};
               4'd5: qd_left[7:0] = b;
               4'd6: an_left = {b, 8'h00};
               4'd7: an_left[7:0] = b;
               default: ;
            endcase
            if (hdr_pos >= HeaderLastIndex) begin
               if (msg_id != expected_id_copy) begin
                  parse_ph = PhBadId;
               end else if (msg_rcode != 0) begin
                  parse_ph = PhRcode;
               end else begin
                  open_questions();
               end
            end else begin
               hdr_pos = hdr_pos + 4'd1;
            end
         end
         PhQName:    take_name_byte(b, 1'b0);
         PhQLabel:   take_label_byte(1'b0);
         PhQPointer: close_name(1'b0);
         PhQFixed: begin
            if (fix_pos >= QuestionFixedLast) begin
               qd_left = qd_left - 16'd1;
               open_questions();
            end else begin
               fix_pos = fix_pos + 4'd1;
            end
         end
         PhAName:    take_name_byte(b, 1'b1);
         PhALabel:   take_label_byte(1'b1);
         PhAPointer: close_name(1'b1);
         PhAFixed: begin
            case (fix_pos)
               4'd0: rr_type = {b, 8'h00};
               4'd1: rr_type[7:0] = b;
               4'd8: rr_len = {b, 8'h00};
               4'd9: rr_len[7:0] = b;
               default: ;
            endcase
            if (fix_pos >= AnswerFixedLast) begin
               if (rr_type == TypeA && rr_len == AddressLength) begin
                  rd_left  = AddressLength;
                  addr_acc = '0;
                  parse_ph = PhACapture;
               end else if (rr_len == 0) begin
                  close_answer();
               end else begin
                  rd_left  = rr_len;
                  parse_ph = PhASkip;
               end
            end else begin
               fix_pos = fix_pos + 4'd1;
            end
         end
         PhASkip: begin
            rd_left = rd_left - 16'd1;
            if (rd_left == 0) begin
               close_answer();
            end
         end
         PhACapture: begin
            addr_acc = {addr_acc[23:0], b};
            rd_left  = rd_left - 16'd1;
            if (rd_left == 0) begin
               addr_done = 1'b1;
               parse_ph  = PhDone;
            end
         end
         default: ;
      endcase

      if (last) begin
         has_result      = 1'b1;
         outcome.found   = addr_done;
         outcome.address = addr_done ? addr_acc : 32'h0;
         if (parse_ph == PhHeader) begin
            outcome.status = StatusShort;
         end else if (parse_ph == PhBadId) begin
            outcome.status = StatusBadId;
         end else if (parse_ph == PhRcode) begin
            outcome.status = StatusRcode;
         end else if (addr_done) begin
            outcome.status = StatusFound;
         end else begin
            outcome.status = StatusNoRecord;
         end
         clear_parse();
      end
   endfunction

   // Message assembly helpers.
   function automatic void put_random(input int n);
      for (int i = 0; i < n; i++) begin
         reply_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   function automatic void put_word(input logic [15:0] w);
      reply_bytes.push_back(w[15:8]);
      reply_bytes.push_back(w[7:0]);
   endfunction

   function automatic void put_header(input logic [15:0] id, input logic [3:0] rcode,
                                      input logic [15:0] qd, input logic [15:0] an);
      logic [3:0] upper;
      upper = 4'($urandom_range(0, 15));
      put_word(id);
      put_random(1);
      reply_bytes.push_back({upper, rcode});
      put_word(qd);
      put_word(an);
      put_random(4);
   endfunction

   function automatic void put_label(input int len);
      reply_bytes.push_back(8'(len));
      put_random(len);
   endfunction

   function automatic void put_name(input int labels, input int max_len, input logic pointer);
      for (int i = 0; i < labels; i++) begin
         put_label($urandom_range(1, max_len));
      end
      if (pointer) begin
         reply_bytes.push_back(8'($urandom_range(8'hC0, 8'hFF)));
         put_random(1);
      end else begin
         reply_bytes.push_back(8'h00);
      end
   endfunction

   function automatic void put_question(input int labels, input int max_len,
                                        input logic pointer);
      put_name(labels, max_len, pointer);
      put_random(4);
   endfunction

   function automatic void put_record(input logic [15:0] rtype, input logic [15:0] rdlen,
                                      input int labels, input int max_len,
                                      input logic pointer, input logic [31:0] addr);
      put_name(labels, max_len, pointer);
      put_word(rtype);
      put_random(6);
      put_word(rdlen);
      if (rtype == TypeA && rdlen == AddressLength) begin
         put_word(addr[31:16]);
         put_word(addr[15:0]);
      end else begin
         put_random(rdlen > 40 ? 40 : rdlen);
      end
   endfunction

   // Offers one byte, with an occasional gap before it, and waits for it to be taken.
   task automatic send_byte(input logic [7:0] b, input logic last,
                            output logic has_result, output result_type outcome);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      parse_reply_byte(b, last, has_result, outcome);
   endtask

   // Sends the assembled message; the last byte raises one lookup result.
   task automatic send_reply(input logic typed, input result_type want);
      logic       has_result;
      result_type outcome;
      has_result = 1'b0;
      for (int i = 0; i < reply_bytes.size(); i++) begin
         send_byte(reply_bytes[i], i == reply_bytes.size() - 1, has_result, outcome);
      end
      if (has_result) begin
         dns_results_due.push_back(typed ? want : outcome);
      end
      replies_sent++;
   endtask

   // The id register is only written once the block has drained.
   task automatic write_expected_id(input logic [15:0] value);
      req_valid <= 1'b0;
      while (dns_results_due.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_expected_id <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid        <= 1'b0;
      expected_id_copy = value;
      id_writes++;
   endtask

   // Result side: checks each delivered result and throttles with random stalls.
   initial begin
      result_type want;
      logic       next_stall;
      int         burst_left;
      int         hold_left;
      int         hold_served;
      burst_left  = 0;
      hold_left   = 0;
      hold_served = 0;
      forever begin
         @(posedge clock);
         if (!reset && req_valid && req_stall) begin
            block_stall_cycles++;
         end
         if (!reset && rsp_valid && !rsp_stall) begin
            results_seen++;
            if (dns_results_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("ERROR: unexpected result found=%0d address=%h status=%0d",
                           rsp_found, rsp_address, rsp_status);
               end
            end else begin
               want = dns_results_due.pop_front();
               if (rsp_found !== want.found || rsp_address !== want.address ||
                   rsp_status !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("ERROR: result %0d expected found=%0d address=%h status=%0d, %s",
                              results_seen, want.found, want.address, want.status,
                              $sformatf("got found=%0d address=%h status=%0d",
                                        rsp_found, rsp_address, rsp_status));
                  end
               end
               if (rsp_found === 1'b1) begin
                  addresses_found++;
               end
            end
         end

         // Pick the stall for the next cycle: a long hold when asked, else short bursts.
         if (hold_left > 0) begin
            hold_left--;
            next_stall = 1'b1;
         end else if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HoldCycles - 1;
            next_stall  = 1'b1;
         end else if (burst_left > 0) begin
            burst_left--;
            next_stall = 1'b1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(1, 7) - 1;
            next_stall = 1'b1;
         end else begin
            next_stall = 1'b0;
         end
         rsp_stall <= next_stall;
      end
   end

   // Watchdog on the whole run.
   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, dns_results_due.size());
      $display("*** FAILED ***");
      $finish;
   end

   // Stimulus: reset, directed replies, then random replies in several id settings.
   initial begin
      reply_row_type row_now;
      logic [15:0]   tx_id;
      logic [15:0]   new_id;
      logic [15:0]   rtype;
      logic [15:0]   rdlen;
      logic [3:0]    rcode;
      int            seg;
      int            seg_start;
      int            seg_replies;
      int            n_q;
      int            n_a;
      int            pick;
      int            cut;

      clear_parse();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed replies; the first ones rely on the id register's reset value.
      for (int r = 0; r < NumRows; r++) begin
         row_now = plan[r];
         if (row_now.kind == KindWriteId) begin
            write_expected_id(row_now.arg[15:0]);
         end else begin
            reply_bytes.delete();
            case (row_now.kind)
               KindFound: begin
                  put_header(expected_id_copy, 4'h0, 16'd1, 16'd1);
                  put_question(2, 8, 1'b0);
                  put_record(TypeA, AddressLength, 1, 8, 1'b0, row_now.arg);
               end
               KindOneByte: begin
                  put_random(1);
               end
               KindShortHeader: begin
                  put_header(expected_id_copy, 4'h0, 16'd1, 16'd1);
                  void'(reply_bytes.pop_back());
               end
               KindEmpty: begin
                  put_header(expected_id_copy, 4'h0, 16'd0, 16'd0);
               end
               KindBadId: begin
                  // A wrong id wins over a nonzero response code.
                  put_header(~expected_id_copy, 4'h5, 16'd1, 16'd1);
                  put_question(1, 8, 1'b0);
                  put_record(TypeA, AddressLength, 1, 8, 1'b0, $urandom);
               end
               KindRcode: begin
                  put_header(expected_id_copy, RcodeMask, 16'd1, 16'd1);
                  put_question(1, 8, 1'b0);
                  put_record(TypeA, AddressLength, 1, 8, 1'b0, $urandom);
               end
               KindPointer: begin
                  put_header(expected_id_copy, 4'h0, 16'd2, 16'd2);
                  put_question(0, 8, 1'b1);
                  put_question(3, 8, 1'b1);
                  put_record(TypeCname, 16'd2, 0, 8, 1'b1, 32'h0);
                  put_record(TypeA, AddressLength, 2, 8, 1'b1, $urandom);
               end
               KindSkipFirst: begin
                  // Long A data and an empty record are skipped; a second A is ignored.
                  put_header(expected_id_copy, 4'h0, 16'd1, 16'd4);
                  put_question(1, 8, 1'b0);
                  put_record(TypeA, 16'd8, 1, 8, 1'b0, 32'h0);
                  put_record(TypeCname, 16'd0, 1, 8, 1'b0, 32'h0);
                  put_record(TypeA, AddressLength, 0, 8, 1'b1, row_now.arg);
                  put_record(TypeA, AddressLength, 0, 8, 1'b1, $urandom);
               end
               KindLongLabel: begin
                  put_header(expected_id_copy, 4'h0, 16'd1, 16'd1);
                  put_label(64);
                  put_label(191);
                  reply_bytes.push_back(8'h00);
                  put_random(4);
                  put_record(TypeA, AddressLength, 1, 8, 1'b0, row_now.arg);
               end
               KindMaxLabels: begin
                  put_header(expected_id_copy, 4'h0, 16'd0, 16'd1);
                  put_record(TypeA, AddressLength, LabelLimit, 1, 1'b0, row_now.arg);
               end
               KindTooManyLabels: begin
                  put_header(expected_id_copy, 4'h0, 16'd1, 16'd1);
                  put_question(LabelLimit + 1, 1, 1'b0);
                  put_record(TypeA, AddressLength, 1, 8, 1'b0, $urandom);
               end
               KindTruncated: begin
                  put_header(expected_id_copy, 4'h0, 16'd0, 16'd1);
                  put_record(TypeA, AddressLength, 1, 8, 1'b0, row_now.arg);
                  void'(reply_bytes.pop_back());
                  void'(reply_bytes.pop_back());
               end
               KindTrailing: begin
                  put_header(expected_id_copy, 4'h0, 16'd0, 16'd1);
                  put_record(TypeA, AddressLength, 1, 8, 1'b0, row_now.arg);
                  put_random(5);
               end
               KindHugeCounts: begin
                  put_header(expected_id_copy, 4'h0, 16'hFFFF, 16'hFFFF);
                  put_question(1, 8, 1'b0);
                  put_question(0, 8, 1'b1);
               end
               KindHugeLength: begin
                  put_header(expected_id_copy, 4'h0, 16'd0, 16'hFFFF);
                  put_record(TypeA, 16'hFFFF, 1, 8, 1'b0, 32'h0);
               end
               KindNoA: begin
                  put_header(expected_id_copy, 4'h0, 16'd1, 16'd3);
                  put_question(1, 8, 1'b0);
                  put_record(TypeAaaa, 16'd16, 1, 8, 1'b0, 32'h0);
                  put_record(TypeCname, AddressLength, 1, 8, 1'b1, 32'h0);
                  put_record(TypeA, 16'd5, 0, 8, 1'b1, 32'h0);
               end
               default: ;
            endcase
            send_reply(row_now.typed, row_now.want);
         end
      end

      // Random replies: mostly well-formed with random content, some noise and damage.
      for (seg = 0; seg < 4; seg++) begin
         case (seg)
            0:       new_id = 16'($urandom_range(0, 65535));
            1:       new_id = 16'hFFFF;
            2:       new_id = 16'h0000;
            default: new_id = 16'($urandom_range(0, 65535));
         endcase
         write_expected_id(new_id);
         idle_on     = (seg != 3);
         seg_start   = bytes_sent;
         seg_replies = 0;
         while (bytes_sent - seg_start < SegmentBytes || seg_replies < SegmentReplies) begin
            reply_bytes.delete();
            if ($urandom_range(0, 9) == 0) begin
               put_random($urandom_range(1, 30));
            end else begin
               tx_id = ($urandom_range(0, 11) == 0) ? 16'($urandom_range(0, 65535))
                                                     : expected_id_copy;
               rcode = ($urandom_range(0, 11) == 0) ? 4'($urandom_range(1, 15)) : 4'h0;
               n_q   = $urandom_range(0, 2);
               n_a   = $urandom_range(0, 4);
               put_header(tx_id, rcode,
                          ($urandom_range(0, 29) == 0) ? 16'($urandom_range(0, 65535))
                                                        : 16'(n_q),
                          ($urandom_range(0, 29) == 0) ? 16'($urandom_range(0, 65535))
                                                        : 16'(n_a));
               for (int q = 0; q < n_q; q++) begin
                  if ($urandom_range(0, 29) == 0) begin
                     put_question(LabelLimit + $urandom_range(0, 1), 1, 1'b0);
                  end else begin
                     put_question($urandom_range(0, 3), 8, $urandom_range(0, 2) == 0);
                  end
               end
               for (int a = 0; a < n_a; a++) begin
                  pick = $urandom_range(0, 9);
                  if (pick < 5) begin
                     rtype = TypeA;
                  end else if (pick < 7) begin
                     rtype = TypeCname;
                  end else if (pick < 8) begin
                     rtype = TypeAaaa;
                  end else begin
                     rtype = 16'($urandom_range(0, 65535));
                  end
                  if (rtype == TypeA && $urandom_range(0, 4) != 0) begin
                     rdlen = AddressLength;
                  end else begin
                     rdlen = 16'($urandom_range(0, 10));
                  end
                  if ($urandom_range(0, 49) == 0) begin
                     rdlen = 16'($urandom_range(0, 65535));
                  end
                  put_record(rtype, rdlen, $urandom_range(0, 3), 8,
                             $urandom_range(0, 2) == 0, $urandom);
               end
               // Cut the message short now and then, or add bytes past the parse.
               if ($urandom_range(0, 7) == 0) begin
                  cut = $urandom_range(1, reply_bytes.size());
                  while (reply_bytes.size() > cut) begin
                     void'(reply_bytes.pop_back());
                  end
               end
               if ($urandom_range(0, 7) == 0) begin
                  put_random($urandom_range(1, 5));
               end
            end
            send_reply(1'b0, '0);
            seg_replies++;
         end

         // Back-pressure: the result side holds off while tiny replies keep coming.
         if (seg == 0) begin
            idle_on = 1'b0;
            hold_requests++;
            for (int p = 0; p < 40; p++) begin
               reply_bytes.delete();
               put_random($urandom_range(1, 3));
               send_reply(1'b0, '0);
            end
         end
      end

      // Drain and report.
      req_valid <= 1'b0;
      while (dns_results_due.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      $display("Checked %0d lookup results from %0d replies (%0d bytes), %0d with an address.",
               results_seen, replies_sent, bytes_sent, addresses_found);
      $display("Id register written %0d times; input held off %0d cycles; %0d mismatches.",
               id_writes, block_stall_cycles, mismatches);
      if (mismatches == 0 && dns_results_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: dns_reply_a_record_extractor.f
rtl/dnsa_pkg.sv
rtl/dns_reply_a_record_extractor.sv
tb/sv/dns_reply_a_record_extractor_tb.sv
